// File: rtl/mb32_pkg.sv
// Shared types and constants of the Mulberry32 range and dice core.
package mb32_pkg;

  typedef enum logic [1:0] {
    KIND_RESEED = 2'd0,
    KIND_RAW    = 2'd1,
    KIND_RANGE  = 2'd2,
    KIND_DICE   = 2'd3
  } mb32_kind_t;

  localparam logic [31:0] GOLDEN_STEP = 32'h6d2b_79f5;
  localparam logic [31:0] MIX_ODD_A   = 32'd1;
  localparam logic [31:0] MIX_ODD_B   = 32'd61;
  localparam int          QUEUE_DEPTH = 2;
  localparam int          SUM_W       = 21;

  typedef struct packed {
    mb32_kind_t         kind;
    logic [31:0]        seed_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [4:0]         dice_count;
    logic [15:0]        dice_sides;
  } mb32_in_t;

  typedef struct packed {
    logic signed [32:0] value;
    logic               bad_request;
  } mb32_out_t;

  typedef struct packed {
    mb32_kind_t  kind;
    logic [31:0] operand;
    logic [32:0] span;
    logic [4:0]  count;
    logic        bad;
  } mb32_op_t;

endpackage

// File: rtl/mb32_front.sv
// Input stage that accepts requests, checks them and forms queue entries.
module mb32_front #(
  parameter int MAX_DICE = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mb32_pkg::mb32_in_t in_data,
  output logic             push_valid,
  input  logic             push_ready,
  output mb32_pkg::mb32_op_t push_op
);

  logic               valid_r;
  mb32_pkg::mb32_op_t op_r;
  mb32_pkg::mb32_op_t op_nxt;
  logic [32:0]        diff;

  assign diff = {in_data.range_high[31], in_data.range_high}
              - {in_data.range_low[31], in_data.range_low};

  always_comb begin
    op_nxt.kind    = in_data.kind;
    op_nxt.operand = in_data.seed_value;
    op_nxt.span    = 33'd0;
    op_nxt.count   = 5'd0;
    op_nxt.bad     = 1'b0;
    unique case (in_data.kind)
      mb32_pkg::KIND_RESEED: begin
        op_nxt.operand = in_data.seed_value;
      end
      mb32_pkg::KIND_RAW: begin
        op_nxt.span = 33'd0;
      end
      mb32_pkg::KIND_RANGE: begin
        op_nxt.operand = in_data.range_low;
        op_nxt.bad     = (in_data.range_high < in_data.range_low);
        op_nxt.span    = diff + 33'd1;
      end
      mb32_pkg::KIND_DICE: begin
        op_nxt.span = {17'd0, in_data.dice_sides};
        op_nxt.bad  = (in_data.dice_sides == 16'd0);
        if (32'(in_data.dice_count) > 32'(MAX_DICE)) begin
          op_nxt.count = 5'(MAX_DICE);
        end else begin
          op_nxt.count = in_data.dice_count;
        end
      end
      default: begin
        op_nxt.bad = 1'b0;
      end
    endcase
  end

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_op    = op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= op_nxt;
    end
  end

endmodule

// File: rtl/mb32_queue.sv
// Short first-in first-out queue between the front and the generator engine.
module mb32_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  mb32_pkg::mb32_op_t push_op,
  output logic             pop_valid,
  input  logic             pop_ready,
  output mb32_pkg::mb32_op_t pop_op
);

  localparam int PTR_W = (mb32_pkg::QUEUE_DEPTH > 1) ? $clog2(mb32_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mb32_pkg::QUEUE_DEPTH + 1);

  mb32_pkg::mb32_op_t entry_r [mb32_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (cnt_r != CNT_W'(mb32_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_op     = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(mb32_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(mb32_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(mb32_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

// File: rtl/mb32_engine.sv
// Generator engine that advances the state, mixes, scales and sums draws.
module mb32_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  mb32_pkg::mb32_op_t pop_op,
  output logic              out_valid,
  input  logic              out_ready,
  output mb32_pkg::mb32_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_MIX1, S_MIX2, S_MIX3, S_SCALE, S_ACC, S_DONE
  } state_t;

  state_t                    state_r;
  mb32_pkg::mb32_op_t         op_r;
  logic [31:0]               gen_r;
  logic [31:0]               t1_r;
  logic [31:0]               m_r;
  logic [31:0]               u_r;
  logic [31:0]               scaled_r;
  logic [4:0]                rem_r;
  logic [mb32_pkg::SUM_W-1:0] sum_r;
  logic [32:0]               res_value_r;
  logic                      res_bad_r;
  logic                      out_valid_r;
  mb32_pkg::mb32_out_t        out_data_r;

  logic [31:0]               mix1;
  logic [31:0]               mix2;
  logic [31:0]               t3;
  logic [63:0]               prod;
  logic [31:0]               scaled;
  logic [mb32_pkg::SUM_W-1:0] sum_nxt;
  logic                      out_free;

  assign mix1    = (gen_r ^ (gen_r >> 15)) * (gen_r | mb32_pkg::MIX_ODD_A);
  assign mix2    = (t1_r ^ (t1_r >> 7)) * (t1_r | mb32_pkg::MIX_ODD_B);
  assign t3      = (t1_r + m_r) ^ t1_r;
  assign prod    = 64'(u_r) * 64'(op_r.span[31:0]);
  assign scaled  = op_r.span[32] ? u_r : prod[63:32];
  assign sum_nxt = sum_r + mb32_pkg::SUM_W'(scaled_r[15:0]) + mb32_pkg::SUM_W'(1);

  assign out_free  = !out_valid_r || out_ready;
  assign pop_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gen_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            op_r  <= pop_op;
            rem_r <= pop_op.count;
            sum_r <= '0;
            if (pop_op.kind == mb32_pkg::KIND_RESEED) begin
              gen_r <= pop_op.operand;
            end else if (pop_op.bad) begin
              res_value_r <= 33'd0;
              res_bad_r   <= 1'b1;
              state_r     <= S_DONE;
            end else if (pop_op.kind == mb32_pkg::KIND_DICE && pop_op.count == 5'd0) begin
              res_value_r <= 33'd0;
              res_bad_r   <= 1'b0;
              state_r     <= S_DONE;
            end else begin
              gen_r   <= gen_r + mb32_pkg::GOLDEN_STEP;
              state_r <= S_MIX1;
            end
          end
        end
        S_MIX1: begin
          t1_r    <= mix1;
          state_r <= S_MIX2;
        end
        S_MIX2: begin
          m_r     <= mix2;
          state_r <= S_MIX3;
        end
        S_MIX3: begin
          u_r     <= t3 ^ (t3 >> 14);
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          scaled_r <= scaled;
          state_r  <= S_ACC;
        end
        S_ACC: begin
          res_bad_r <= 1'b0;
          unique case (op_r.kind)
            mb32_pkg::KIND_RANGE: begin
              res_value_r <= {op_r.operand[31], op_r.operand} + {1'b0, scaled_r};
              state_r     <= S_DONE;
            end
            mb32_pkg::KIND_DICE: begin
              sum_r <= sum_nxt;
              if (rem_r > 5'd1) begin
                rem_r   <= rem_r - 5'd1;
                gen_r   <= gen_r + mb32_pkg::GOLDEN_STEP;
                state_r <= S_MIX1;
              end else begin
                res_value_r <= 33'(sum_nxt);
                state_r     <= S_DONE;
              end
            end
            default: begin
              res_value_r <= {1'b0, u_r};
              state_r     <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r.value       <= res_value_r;
            out_data_r.bad_request <= res_bad_r;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_reseed_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && pop_valid && pop_op.kind == mb32_pkg::KIND_RESEED)
    |=> (gen_r == $past(pop_op.operand)))
    else $error("reseed did not load the generator word");

  a_dice_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX1 && op_r.kind == mb32_pkg::KIND_DICE) |-> (rem_r != 5'd0))
    else $error("dice draw started with no dice left");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_free) |=> (state_r == S_DONE))
    else $error("result dropped while output register was full");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.bad_request) |-> (out_data_r.value == 33'sd0))
    else $error("bad request carries a nonzero value");

endmodule

// File: rtl/mulberry32_range_and_dice_core.sv
// Top level of the Mulberry32 range and dice core.
// A request passes a registered input check stage and a two-entry queue before the
// generator engine takes it, so new requests are accepted while the engine works.
// In the engine a reseed loads the generator word and gives no result; a bad request or
// a roll of zero dice goes straight to S_DONE; a raw or range request makes one draw and
// a dice roll one draw per die. Each draw passes S_MIX1, S_MIX2, S_MIX3, S_SCALE and
// S_ACC, as the two dependent multiplies of the mixer and the scaling multiply each
// have a register behind them. The generator word resets to zero.
module mulberry32_range_and_dice_core #(
  parameter int MAX_DICE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mb32_pkg::mb32_in_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mb32_pkg::mb32_out_t out_data
);

  logic               push_valid;
  logic               push_ready;
  mb32_pkg::mb32_op_t push_op;
  logic               pop_valid;
  logic               pop_ready;
  mb32_pkg::mb32_op_t pop_op;

  mb32_front #(
    .MAX_DICE(MAX_DICE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_op   (push_op)
  );

  mb32_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_op   (push_op),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op)
  );

  mb32_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_op   (pop_op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: tb/sv/mulberry32_range_and_dice_core_test.sv
// Self-checking testbench for the Mulberry32 range and dice core with a prediction scoreboard.
`timescale 1ns / 1ps

class draw_ledger;
  logic [31:0]         gen_word;
  mb32_pkg::mb32_out_t awaited[$];
  int                  mismatches;
  int                  dice_limit;

  function new(int lim);
    gen_word   = '0;
    mismatches = 0;
    dice_limit = lim;
  endfunction

  function logic [31:0] next_word();
    logic [31:0] s;
    logic [31:0] t;
    gen_word = gen_word + mb32_pkg::GOLDEN_STEP;
    s = gen_word;
    t = (s ^ (s >> 15)) * (mb32_pkg::MIX_ODD_A | s);
    t = (t + (t ^ (t >> 7)) * (mb32_pkg::MIX_ODD_B | t)) ^ t;
    return t ^ (t >> 14);
  endfunction

  // The span may be the full 2^32, so it needs 33 bits.
  function logic [31:0] scaled_draw(logic [32:0] span);
    logic [31:0] u;
    logic [63:0] prod;
    u = next_word();
    prod = {32'd0, u} * {31'd0, span};
    return prod[63:32];
  endfunction

  function void note_request(mb32_pkg::mb32_in_t req);
    mb32_pkg::mb32_out_t res;
    longint              lo;
    longint              hi;
    longint              sum;
    logic [63:0]         wide;
    int                  n;
    res = '0;
    case (req.kind)
      mb32_pkg::KIND_RESEED: begin
        gen_word = req.seed_value;
        return;
      end
      mb32_pkg::KIND_RAW: begin
        res.value = {1'b0, next_word()};
      end
      mb32_pkg::KIND_RANGE: begin
        lo = req.range_low;
        hi = req.range_high;
        if (hi < lo) begin
          res.bad_request = 1'b1;
        end else begin
          wide = hi - lo + 1;
          wide = lo + scaled_draw(wide[32:0]);
          res.value = wide[32:0];
        end
      end
      default: begin
        if (req.dice_sides == 0) begin
          res.bad_request = 1'b1;
        end else begin
          n = (req.dice_count > dice_limit) ? dice_limit : req.dice_count;
          sum = 0;
          repeat (n) sum += 1 + scaled_draw({17'd0, req.dice_sides});
          wide = sum;
          res.value = wide[32:0];
        end
      end
    endcase
    awaited.insert(awaited.size(), res);
  endfunction

  function void check_result(mb32_pkg::mb32_out_t got);
    mb32_pkg::mb32_out_t want;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected item, expected none, got value %0h bad_request %0b",
               $time, got.value, got.bad_request);
      mismatches++;
      return;
    end
    want = awaited.pop_front();
    if (got.value !== want.value) begin
      $display("%0t: value expected %0h, got %0h", $time, want.value, got.value);
      mismatches++;
    end
    if (got.bad_request !== want.bad_request) begin
      $display("%0t: bad_request expected %0b, got %0b",
               $time, want.bad_request, got.bad_request);
      mismatches++;
    end
  endfunction
endclass

module mulberry32_range_and_dice_core_test;
  localparam int DICE_LIMIT  = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 880;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  mb32_pkg::mb32_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  mb32_pkg::mb32_out_t out_data;

  draw_ledger ledger = new(DICE_LIMIT);
  int         cycles = 0;
  int         results_seen = 0;
  int         stall_left = 0;
  bit         burst = 1'b0;

  mulberry32_range_and_dice_core #(.MAX_DICE(DICE_LIMIT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("mulberry32_range_and_dice_core_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      ledger.check_result(out_data);
      results_seen++;
      if (results_seen == 200) begin
        stall_left = 400;
      end else begin
        stall_left = burst ? 0 : $urandom_range(0, 7);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic mb32_pkg::mb32_in_t make_req(mb32_pkg::mb32_kind_t k,
                                                  logic [31:0] seed, logic [31:0] lo,
                                                  logic [31:0] hi, logic [4:0] cnt,
                                                  logic [15:0] sides);
    mb32_pkg::mb32_in_t req;
    req.kind       = k;
    req.seed_value = seed;
    req.range_low  = lo;
    req.range_high = hi;
    req.dice_count = cnt;
    req.dice_sides = sides;
    return req;
  endfunction

  function automatic mb32_pkg::mb32_in_t random_request();
    mb32_pkg::mb32_in_t req;
    longint             lo_l;
    longint             hi_l;
    int                 pick;
    logic [63:0]        bits;
    req.seed_value = $urandom;
    req.range_low  = $urandom;
    req.range_high = $urandom;
    req.dice_count = 5'($urandom);
    req.dice_sides = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      req.kind = mb32_pkg::KIND_RESEED;
    end else if (pick < 35) begin
      req.kind = mb32_pkg::KIND_RAW;
    end else if (pick < 70) begin
      req.kind = mb32_pkg::KIND_RANGE;
      lo_l = req.range_low;
      case ($urandom_range(0, 4))
        0: hi_l = req.range_high;
        1: hi_l = lo_l + $urandom_range(0, 100);
        2: hi_l = lo_l + (1 << 21) - 4 + $urandom_range(0, 8);
        3: begin
          lo_l = -64'sd2147483648;
          hi_l = req.range_high;
        end
        default: hi_l = lo_l;
      endcase
      if (hi_l > 2147483647) hi_l = 2147483647;
      bits = lo_l;
      req.range_low = bits[31:0];
      bits = hi_l;
      req.range_high = bits[31:0];
    end else begin
      req.kind = mb32_pkg::KIND_DICE;
      if ($urandom_range(0, 7) != 0) req.dice_count = 5'($urandom_range(0, 6));
      case ($urandom_range(0, 15))
        0:       req.dice_sides = '0;
        1, 2:    req.dice_sides = 16'($urandom);
        default: req.dice_sides = 16'($urandom_range(1, 20));
      endcase
    end
    return req;
  endfunction

  task automatic send_request(input mb32_pkg::mb32_in_t req);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(req);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The first draw comes from the reset state of the generator word.
    send_request(make_req(mb32_pkg::KIND_RAW, '0, '0, '0, '0, '0));
    send_request(make_req(mb32_pkg::KIND_RESEED, 32'hffff_ffff, '0, '0, '0, '0));
    send_request(make_req(mb32_pkg::KIND_RAW, '0, '0, '0, '0, '0));
    send_request(make_req(mb32_pkg::KIND_RANGE, '0, 32'h8000_0000, 32'h7fff_ffff, '0, '0));
    send_request(make_req(mb32_pkg::KIND_RANGE, '0, 32'h7fff_ffff, 32'h7fff_ffff, '0, '0));
    send_request(make_req(mb32_pkg::KIND_RANGE, '0, 32'h8000_0000, 32'h8000_0000, '0, '0));
    send_request(make_req(mb32_pkg::KIND_RANGE, '0, 32'h7fff_ffff, 32'h8000_0000, '0, '0));
    send_request(make_req(mb32_pkg::KIND_RANGE, '0, 32'd5, 32'd4, '0, '0));
    send_request(make_req(mb32_pkg::KIND_RANGE, '0, 32'd0, 32'h001f_ffff, '0, '0));
    send_request(make_req(mb32_pkg::KIND_RANGE, '0, 32'hfff0_0000, 32'h0010_0000, '0, '0));
    send_request(make_req(mb32_pkg::KIND_RESEED, '0, '0, '0, '0, '0));
    send_request(make_req(mb32_pkg::KIND_DICE, '0, '0, '0, 5'd0, 16'd6));
    send_request(make_req(mb32_pkg::KIND_DICE, '0, '0, '0, 5'd0, 16'd0));
    send_request(make_req(mb32_pkg::KIND_DICE, '0, '0, '0, 5'd5, 16'd0));
    send_request(make_req(mb32_pkg::KIND_DICE, '0, '0, '0, 5'd31, 16'hffff));
    send_request(make_req(mb32_pkg::KIND_DICE, '0, '0, '0, 5'd17, 16'd6));
    send_request(make_req(mb32_pkg::KIND_DICE, '0, '0, '0, 5'd16, 16'hffff));
    send_request(make_req(mb32_pkg::KIND_DICE, '0, '0, '0, 5'd1, 16'd1));
    send_request(make_req(mb32_pkg::KIND_RESEED, 32'h1234_5678, 32'hffff_ffff,
                          32'h8000_0000, 5'd31, 16'hffff));
    send_request(make_req(mb32_pkg::KIND_RAW, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                          5'd31, 16'hffff));
    send_request(make_req(mb32_pkg::KIND_RANGE, 32'hffff_ffff, 32'hffff_fff6, 32'd10,
                          5'd31, 16'hffff));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      burst = ((i / 150) % 3 == 2);
      send_request(random_request());
    end
    burst = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
      $display("mulberry32_range_and_dice_core_test: PASS");
    end else begin
      $display("mulberry32_range_and_dice_core_test: FAIL");
    end
    $finish;
  end
endmodule
